// ===== sv/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// shared types, constants and helper functions for the rgba8 tile swizzle
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int DIM_W   = 11;   // tex_width / tex_height
    localparam int CNT_W   = 10;   // column / row counters
    localparam int CAP_W   = 23;   // buffer capacities in bytes
    localparam int OFF_W   = 22;   // byte offset
    localparam int TEXEL_W = 32;
    localparam int LOG_W   = 4;    // log2 of a dimension
    localparam int AREA_W  = 24;   // bytes of a whole image, max 2^22

    localparam logic [DIM_W-1:0] MIN_DIM = 11'd8;
    localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

    // 8x8 tiles, 4 bytes per texel
    localparam int TILE_BITS  = 3;
    localparam int TEXEL_BITS = 2;

    typedef enum logic [1:0] {
        REG_TEX_WIDTH  = 2'd0,
        REG_TEX_HEIGHT = 2'd1,
        REG_DEST_CAP   = 2'd2,
        REG_SRC_CAP    = 2'd3
    } t_reg_idx;

    // decoded configuration; the user keeps it stable while items are in flight, the block does not enforce this
    typedef struct packed {
        logic             ok;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [LOG_W-1:0] log2w;
    } t_cfg_info;

    // item held between the scan stage and the address stage
    typedef struct packed {
        logic               err;
        logic               last;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic [TEXEL_W-1:0] texel;
    } t_scan_item;

    // z order inside a tile, x bit in the lower position
    function automatic logic [2*TILE_BITS-1:0] morton3(
        input logic [TILE_BITS-1:0] x,
        input logic [TILE_BITS-1:0] y
    );
        logic [2*TILE_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < TILE_BITS; b++) begin
            r[2*b]   = x[b];
            r[2*b+1] = y[b];
        end
        return r;
    endfunction

    function automatic logic [TEXEL_W-1:0] byte_rev(input logic [TEXEL_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/tts_cfg.sv =====
// ----------------------------------------------------------------------------
// tts_cfg
// configuration registers and validity check of the image geometry
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cfg
    import tts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CAP_W-1:0]   i_cfg_data,
    output t_cfg_info               o_cfg
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [CAP_W-1:0] r_dest_cap;
    logic [CAP_W-1:0] r_src_cap;

    logic [LOG_W-1:0]  lw;
    logic [LOG_W-1:0]  lh;
    logic              w_ok;
    logic              h_ok;
    logic [4:0]        area_exp;
    logic [AREA_W-1:0] area_bytes;
    logic              cap_ok;
    t_reg_idx          idx;

    assign idx = t_reg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 11'd8;
            r_height   <= 11'd8;
            r_dest_cap <= '0;
            r_src_cap  <= '0;
        end else if (i_cfg_we) begin
            unique case (idx)
                REG_TEX_WIDTH:  r_width    <= i_cfg_data[DIM_W-1:0];
                REG_TEX_HEIGHT: r_height   <= i_cfg_data[DIM_W-1:0];
                REG_DEST_CAP:   r_dest_cap <= i_cfg_data;
                REG_SRC_CAP:    r_src_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // exponent of a power of two dimension
    always_comb begin
        lw = '0;
        lh = '0;
        for (int b = 0; b < DIM_W; b++) begin
            if (r_width[b])  lw = LOG_W'(b);
            if (r_height[b]) lh = LOG_W'(b);
        end
    end

    assign w_ok = $onehot(r_width)  && (r_width  >= MIN_DIM) && (r_width  <= MAX_DIM);
    assign h_ok = $onehot(r_height) && (r_height >= MIN_DIM) && (r_height <= MAX_DIM);

    // with both dimensions powers of two the image size is a power of two too
    assign area_exp   = {1'b0, lw} + {1'b0, lh} + 5'(TEXEL_BITS);
    assign area_bytes = AREA_W'(1) << area_exp;
    assign cap_ok     = (AREA_W'(r_dest_cap) >= area_bytes) &&
                        (AREA_W'(r_src_cap)  >= area_bytes);

    always_comb begin
        o_cfg.ok     = w_ok && h_ok && cap_ok;
        o_cfg.width  = r_width;
        o_cfg.height = r_height;
        o_cfg.log2w  = lw;
    end

endmodule

`default_nettype wire

// ===== sv/tts_scan.sv =====
// ----------------------------------------------------------------------------
// tts_scan
// raster position counters and input register
// ----------------------------------------------------------------------------
`default_nettype none

module tts_scan
    import tts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg_info          i_cfg,
    input  wire logic               i_valid,
    input  wire logic [TEXEL_W-1:0] i_texel,
    output logic                    o_ready,
    input  wire logic               i_adv,
    output logic                    o_valid,
    output t_scan_item              o_item
);

    logic             r_valid;
    t_scan_item       r_item;
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;

    logic             acc;
    logic             outside;
    logic [CNT_W-1:0] cur_col;
    logic [CNT_W-1:0] cur_row;
    logic             cur_last;
    logic [DIM_W-1:0] col_inc;
    logic             row_wrap;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    t_scan_item       n_item;

    assign o_ready = !r_valid || i_adv;
    assign acc     = i_valid && o_ready;

    // restart at the origin when the counters lie outside a resized image
    assign outside  = ({1'b0, r_col} >= i_cfg.width) || ({1'b0, r_row} >= i_cfg.height);
    assign cur_col  = outside ? '0 : r_col;
    assign cur_row  = outside ? '0 : r_row;
    assign cur_last = ({1'b0, cur_col} == i_cfg.width  - 11'd1) &&
                      ({1'b0, cur_row} == i_cfg.height - 11'd1);
    assign col_inc  = {1'b0, cur_col} + 11'd1;
    assign row_wrap = (col_inc == i_cfg.width);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg.ok) begin
            if (cur_last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_wrap) begin
                n_col = '0;
                n_row = cur_row + 10'd1;
            end else begin
                n_col = col_inc[CNT_W-1:0];
                n_row = cur_row;
            end
        end
    end

    always_comb begin
        n_item.err   = !i_cfg.ok;
        n_item.last  = cur_last;
        n_item.col   = cur_col;
        n_item.row   = cur_row;
        n_item.texel = i_texel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (acc) begin
                r_valid <= 1'b1;
                r_col   <= n_col;
                r_row   <= n_row;
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // counters stay inside the image after a good beat
    a_cnt_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cfg.ok) |=> ({1'b0, r_col} < i_cfg.width) && ({1'b0, r_row} < i_cfg.height))
        else $error("position counter left the image");

    // the final texel sends the scan back to the origin
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_cfg.ok && cur_last) |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not wrap after the final texel");

    // a held item is not overwritten while the next stage is blocked
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_adv) |=> r_valid && $stable(r_item))
        else $error("input register changed while stalled");

endmodule

`default_nettype wire

// ===== sv/tts_addr.sv =====
// ----------------------------------------------------------------------------
// tts_addr
// tiled byte offset, byte swap and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tts_addr
    import tts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [LOG_W-1:0]    i_log2w,
    input  wire logic                i_valid,
    input  wire t_scan_item          i_item,
    output logic                     o_adv,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OFF_W-1:0]         o_offset,
    output logic [TEXEL_W-1:0]       o_texel,
    output logic                     o_last,
    output logic                     o_err
);

    localparam int IDX_W = OFF_W - TEXEL_BITS;

    logic               r_valid;
    logic [OFF_W-1:0]   r_offset;
    logic [TEXEL_W-1:0] r_texel;
    logic               r_last;
    logic               r_err;

    logic [OFF_W-1:0]   row_part;
    logic [OFF_W-1:0]   col_part;
    logic [OFF_W-1:0]   texel_idx;
    logic [OFF_W-1:0]   n_offset;
    logic [TEXEL_W-1:0] n_texel;
    logic               n_last;
    logic               take;

    assign o_adv = !r_valid || i_ready;
    assign take  = i_valid && o_adv;

    // aligned row times the power of two width is a shift
    assign row_part  = OFF_W'({i_item.row[CNT_W-1:TILE_BITS], TILE_BITS'(0)}) << i_log2w;
    assign col_part  = OFF_W'({i_item.col[CNT_W-1:TILE_BITS], TILE_BITS'(0)}) << TILE_BITS;
    assign texel_idx = row_part + col_part +
                       OFF_W'(morton3(i_item.col[TILE_BITS-1:0], i_item.row[TILE_BITS-1:0]));

    always_comb begin
        if (i_item.err) begin
            n_offset = '0;
            n_texel  = '0;
            n_last   = 1'b0;
        end else begin
            n_offset = {texel_idx[IDX_W-1:0], TEXEL_BITS'(0)};
            n_texel  = byte_rev(i_item.texel);
            n_last   = i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_offset <= n_offset;
            r_texel  <= n_texel;
            r_last   <= n_last;
            r_err    <= i_item.err;
        end
    end

    assign o_valid  = r_valid;
    assign o_offset = r_offset;
    assign o_texel  = r_texel;
    assign o_last   = r_last;
    assign o_err    = r_err;

endmodule

`default_nettype wire

// ===== sv/texture_tile_swizzle_rgba8_top.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle_rgba8_top
// raster rgba8 texels in, tiled byte offset and abgr texel out
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  -----------------------------------------------------------
//  s_axis    in   tdata[31:0] texel_in
//  m_axis    out  tdata[21:0] dest_byte_offset, [53:22] texel_out,
//                 tlast last_texel, tuser config_error
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
//  one beat per cycle sustained while m_axis is ready; a beat taken on s_axis
//  sits in the input register, then moves to the result register, from which
//  it can be taken on m_axis
//  reset: synchronous active low, registers back to 8x8 with zero capacities,
//  position counters at the origin, both pipeline stages empty
//  a stalled m_axis fills the result register, then the input register,
//  and only then drops s_axis_tready
//
`default_nettype none

module texture_tile_swizzle_rgba8_top
    import tts_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [CAP_W-1:0]    i_cfg_data,

    // texel input
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [31:0]         s_axis_tdata,   // texel_in

    // result output
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [55:0]              m_axis_tdata,   // dest_byte_offset, texel_out, pad
    output logic                     m_axis_tlast,   // last_texel
    output logic                     m_axis_tuser    // config_error
);

    t_cfg_info          cfg;
    t_scan_item         item;
    logic               item_valid;
    logic               adv;
    logic [OFF_W-1:0]   offset;
    logic [TEXEL_W-1:0] texel;

    // configuration registers and geometry check
    tts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // raster counters, captured with the texel at acceptance
    tts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .i_texel (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_adv   (adv),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // address math and result register
    tts_addr u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_log2w  (cfg.log2w),
        .i_valid  (item_valid),
        .i_item   (item),
        .o_adv    (adv),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_offset (offset),
        .o_texel  (texel),
        .o_last   (m_axis_tlast),
        .o_err    (m_axis_tuser)
    );

    // pack fields from the lowest bit up, pad to whole bytes
    assign m_axis_tdata = {2'b00, texel, offset};

    // an error beat carries nothing but the flag
    a_err_beat_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("error beat carries data");

endmodule

`default_nettype wire
